// File: src/dbpg_pkg.sv
// ----------------------------------------------------------------------------
// dbpg_pkg: shared types and constants for the dodge/burn pixel gain block
// Fixed-point constants, tone and register codes, and the exp2 lookup table.
// ----------------------------------------------------------------------------
package dbpg_pkg;

  // exp2 table resolution: 2^EXP_TABLE_BITS segments over one octave
  localparam int EXP_TABLE_BITS = 6;
  localparam int TBL_N          = 1 << EXP_TABLE_BITS;
  localparam int FRAC_SH        = 12 - EXP_TABLE_BITS;

  localparam int NUM_STAGES = 10;
  localparam int CFG_DATA_W = 12;

  // Rec.709 luma weights, scaled so that 255 * sum lands on Q0.16
  localparam logic [15:0] LUMA_R    = 16'd13933;
  localparam logic [15:0] LUMA_G    = 16'd46871;
  localparam logic [15:0] LUMA_B    = 16'd4732;
  localparam logic [23:0] LUMA_BIAS = 24'd127;
  // ceil(2^31 / 255): exact floor division for sums below 2^24
  localparam logic [23:0] LUMA_RECIP = 24'd8421505;
  localparam int          LUMA_SH    = 31;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // exponent = round(|ev*net*w| * 5 / (4096 * 2805)), half away from zero
  localparam logic [37:0] E_HALF  = 38'd5744640;
  // ceil(2^38 / 2805): exact floor division for 26-bit numerators
  localparam logic [26:0] E_RECIP = 27'd97995689;
  localparam int          E_SH    = 38;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  typedef enum logic [1:0] {
    TONE_MID       = 2'd0,
    TONE_SHADOW    = 2'd1,
    TONE_HIGHLIGHT = 2'd2
  } tone_e;

  typedef enum logic [0:0] {
    CFG_EXPOSURE_EV = 1'b0,
    CFG_TONE_RANGE  = 1'b1
  } cfg_idx_e;

  // pixel side band carried along the pipe
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bypass;
  } pix_t;

  typedef logic [TBL_N:0][17:0] exp_tbl_t;

  // 2^(i/TBL_N) in Q16, via a Q30 Taylor series of e^x, evaluated at elaboration
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= TBL_N; i++) begin
      t    = (64'(i) * LN2_Q30 + 64'(TBL_N / 2)) / 64'(TBL_N);
      term = 64'd1 << 30;
      sum  = term;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * t) >> 30) / 64'(n);
        sum  = sum + term;
      end
      tbl[i] = 18'((sum + (64'd1 << 13)) >> 14);
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

// File: src/dbpg_in_if.sv
// ----------------------------------------------------------------------------
// dbpg_in_if: input pixel stream
// RGB plus dodge and burn mask levels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbpg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] dodge_level;
  logic [7:0] burn_level;

  modport source (
    output valid, red_in, green_in, blue_in, dodge_level, burn_level,
    input  ready
  );

  modport sink (
    input  valid, red_in, green_in, blue_in, dodge_level, burn_level,
    output ready
  );
endinterface

// File: src/dbpg_out_if.sv
// ----------------------------------------------------------------------------
// dbpg_out_if: output pixel stream
// Adjusted RGB, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbpg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

// File: src/dodge_burn_pixel_gain.sv
// ----------------------------------------------------------------------------
// dodge_burn_pixel_gain: per-pixel dodge and burn exposure gain
// Scales RGB by 2^(ev * net * weight / 2.2) with a luma-based tonal weight.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one pixel per beat: RGB plus dodge and burn mask levels.
//   pix_o carries the adjusted RGB, one beat for every input beat, in order.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write exposure_ev (index 0, signed 1/256 EV)
//   and tone_range (index 1: midtones, shadows, highlights); write only while
//   no pixel is in flight.
//   The stages, from input beat to output valid, are: luma sum, luma
//   divide, weight square, exponent product, rounding bias, exponent divide,
//   table lookup, interpolation, octave shift, channel scaling. Throughput is
//   one pixel per cycle while the receiver keeps pix_o.ready high.
//   Where dodge equals burn the pixel leaves unchanged, through the same stages.
//   Reset clears the configuration (ev 0, midtones) and all valid bits.
//   When the receiver stalls, each stage keeps its beat only if the next one
//   is still full, so bubbles close up and input keeps flowing until the
//   whole pipe is full; then pix_i.ready drops. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module dodge_burn_pixel_gain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [dbpg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dbpg_in_if.sink                         pix_i,
  dbpg_out_if.source                      pix_o
);

  localparam int NStg = dbpg_pkg::NUM_STAGES;

  // configuration registers
  logic signed [11:0] ev_q;
  logic [1:0]         tone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q   <= '0;
      tone_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbpg_pkg::CFG_EXPOSURE_EV: ev_q   <= $signed(cfg_wdata_i[11:0]);
        dbpg_pkg::CFG_TONE_RANGE:  tone_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables; a stage loads when it is
  // empty or its beat moves on
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] vld_d;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !vld_q[NStg-1] || pix_o.ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = pix_i.valid;
    end
    for (int k = 1; k < NStg; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = adv[0];
  assign pix_o.valid = vld_q[NStg-1];

  // datapath
  logic [16:0]        w;
  logic signed [19:0] evnet;
  dbpg_pkg::pix_t     side_w;
  logic [14:0]        emag;
  logic               eneg;
  dbpg_pkg::pix_t     side_e;
  logic [15:0]        gain;
  dbpg_pkg::pix_t     side_g;

  dbpg_weight u_weight (
    .clk_i   (clk_i),
    .adv_i   (adv[2:0]),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .dodge_i (pix_i.dodge_level),
    .burn_i  (pix_i.burn_level),
    .ev_i    (ev_q),
    .tone_i  (tone_q),
    .w_o     (w),
    .evnet_o (evnet),
    .side_o  (side_w)
  );

  dbpg_exponent u_exponent (
    .clk_i   (clk_i),
    .adv_i   (adv[5:3]),
    .w_i     (w),
    .evnet_i (evnet),
    .side_i  (side_w),
    .emag_o  (emag),
    .neg_o   (eneg),
    .side_o  (side_e)
  );

  dbpg_exp2 u_exp2 (
    .clk_i  (clk_i),
    .adv_i  (adv[8:6]),
    .emag_i (emag),
    .neg_i  (eneg),
    .side_i (side_e),
    .gain_o (gain),
    .side_o (side_g)
  );

  dbpg_scale u_scale (
    .clk_i   (clk_i),
    .adv_i   (adv[9]),
    .gain_i  (gain),
    .side_i  (side_g),
    .red_o   (pix_o.red_out),
    .green_o (pix_o.green_out),
    .blue_o  (pix_o.blue_out)
  );

endmodule

// File: src/dbpg_weight.sv
// ----------------------------------------------------------------------------
// dbpg_weight: luma and tonal weight, stages 1 to 3
// Luma sum and ev*net, luma by reciprocal, then the squared tonal weight.
// ----------------------------------------------------------------------------
module dbpg_weight (
  input  logic                clk_i,
  input  logic [2:0]          adv_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          dodge_i,
  input  logic [7:0]          burn_i,
  input  logic signed [11:0]  ev_i,
  input  logic [1:0]          tone_i,
  output logic [16:0]         w_o,
  output logic signed [19:0]  evnet_o,
  output dbpg_pkg::pix_t      side_o
);

  // stage 1
  logic [23:0]        sum_d;
  logic signed [8:0]  net;
  logic signed [19:0] evnet_d;
  dbpg_pkg::pix_t     side_d;

  logic [23:0]        s1_sum_q;
  logic signed [19:0] s1_evnet_q;
  dbpg_pkg::pix_t     s1_side_q;

  assign sum_d = 24'(dbpg_pkg::LUMA_R) * 24'(red_i)
               + 24'(dbpg_pkg::LUMA_G) * 24'(green_i)
               + 24'(dbpg_pkg::LUMA_B) * 24'(blue_i)
               + dbpg_pkg::LUMA_BIAS;
  assign net     = $signed({1'b0, dodge_i}) - $signed({1'b0, burn_i});
  assign evnet_d = 20'(ev_i) * 20'(net);

  always_comb begin
    side_d.red    = red_i;
    side_d.green  = green_i;
    side_d.blue   = blue_i;
    side_d.bypass = (dodge_i == burn_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s1_sum_q   <= sum_d;
      s1_evnet_q <= evnet_d;
      s1_side_q  <= side_d;
    end
  end

  // stage 2: luma = floor(sum / 255)
  logic [47:0]        luma_prod;
  logic [16:0]        s2_luma_q;
  logic signed [19:0] s2_evnet_q;
  dbpg_pkg::pix_t     s2_side_q;

  assign luma_prod = 48'(s1_sum_q) * 48'(dbpg_pkg::LUMA_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s2_luma_q  <= luma_prod[dbpg_pkg::LUMA_SH+16:dbpg_pkg::LUMA_SH];
      s2_evnet_q <= s1_evnet_q;
      s2_side_q  <= s1_side_q;
    end
  end

  // stage 3: tonal weight, Q0.16
  logic [16:0]        inv;
  logic [16:0]        op_a;
  logic [16:0]        op_b;
  logic               is_mid;
  logic [33:0]        sq;
  logic [35:0]        wsum;
  logic [16:0]        s3_w_q;
  logic signed [19:0] s3_evnet_q;
  dbpg_pkg::pix_t     s3_side_q;

  assign inv = dbpg_pkg::ONE_Q16 - s2_luma_q;

  always_comb begin
    case (tone_i)
      dbpg_pkg::TONE_SHADOW: begin
        op_a   = inv;
        op_b   = inv;
        is_mid = 1'b0;
      end
      dbpg_pkg::TONE_HIGHLIGHT: begin
        op_a   = s2_luma_q;
        op_b   = s2_luma_q;
        is_mid = 1'b0;
      end
      default: begin  // midtones, also the unused code
        op_a   = s2_luma_q;
        op_b   = inv;
        is_mid = 1'b1;
      end
    endcase
  end

  assign sq   = 34'(op_a) * 34'(op_b);
  assign wsum = (is_mid ? {sq, 2'b00} : {2'b00, sq}) + 36'd32768;

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      s3_w_q     <= wsum[32:16];
      s3_evnet_q <= s2_evnet_q;
      s3_side_q  <= s2_side_q;
    end
  end

  assign w_o     = s3_w_q;
  assign evnet_o = s3_evnet_q;
  assign side_o  = s3_side_q;

endmodule

// File: src/dbpg_exponent.sv
// ----------------------------------------------------------------------------
// dbpg_exponent: Q3.12 exponent, stages 4 to 6
// Magnitude product, rounding bias, then division by a constant reciprocal.
// ----------------------------------------------------------------------------
module dbpg_exponent (
  input  logic                clk_i,
  input  logic [2:0]          adv_i,
  input  logic [16:0]         w_i,
  input  logic signed [19:0]  evnet_i,
  input  dbpg_pkg::pix_t      side_i,
  output logic [14:0]         emag_o,
  output logic                neg_o,
  output dbpg_pkg::pix_t      side_o
);

  // stage 4: |ev * net| * w
  logic [19:0]    ev_neg;
  logic [18:0]    ev_abs;
  logic [35:0]    mag;
  logic [35:0]    s4_mag_q;
  logic           s4_neg_q;
  dbpg_pkg::pix_t s4_side_q;

  assign ev_neg = 20'd0 - evnet_i;
  assign ev_abs = evnet_i[19] ? ev_neg[18:0] : evnet_i[18:0];
  assign mag    = 36'(ev_abs) * 36'(w_i);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s4_mag_q  <= mag;
      s4_neg_q  <= evnet_i[19];
      s4_side_q <= side_i;
    end
  end

  // stage 5: 5 * mag + half divisor, drop the power-of-two part of the divisor
  logic [37:0]    num;
  logic [25:0]    s5_num_q;
  logic           s5_neg_q;
  dbpg_pkg::pix_t s5_side_q;

  assign num = {s4_mag_q, 2'b00} + 38'(s4_mag_q) + dbpg_pkg::E_HALF;

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s5_num_q  <= num[37:12];
      s5_neg_q  <= s4_neg_q;
      s5_side_q <= s4_side_q;
    end
  end

  // stage 6: divide by 2805
  logic [52:0]    qprod;
  logic [14:0]    s6_emag_q;
  logic           s6_neg_q;
  dbpg_pkg::pix_t s6_side_q;

  assign qprod = 53'(s5_num_q) * 53'(dbpg_pkg::E_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      s6_emag_q <= qprod[dbpg_pkg::E_SH+14:dbpg_pkg::E_SH];
      s6_neg_q  <= s5_neg_q;
      s6_side_q <= s5_side_q;
    end
  end

  assign emag_o = s6_emag_q;
  assign neg_o  = s6_neg_q;
  assign side_o = s6_side_q;

endmodule

// File: src/dbpg_exp2.sv
// ----------------------------------------------------------------------------
// dbpg_exp2: exponent to Q4.12 gain, stages 7 to 9
// Table lookup, linear interpolation, then octave shift with rounding.
// ----------------------------------------------------------------------------
module dbpg_exp2 (
  input  logic           clk_i,
  input  logic [2:0]     adv_i,
  input  logic [14:0]    emag_i,
  input  logic           neg_i,
  input  dbpg_pkg::pix_t side_i,
  output logic [15:0]    gain_o,
  output dbpg_pkg::pix_t side_o
);

  localparam int IdxW = dbpg_pkg::EXP_TABLE_BITS;
  localparam int FSh  = dbpg_pkg::FRAC_SH;
  localparam int IpW  = 19 + FSh;

  // stage 7: split into octave and fraction, read both table neighbors
  logic [15:0]       e_s;
  logic [IdxW:0]     i0;
  logic [IdxW:0]     i1;
  logic [17:0]       t0;
  logic [17:0]       t1;
  logic [17:0]       s7_t0_q;
  logic [17:0]       s7_diff_q;
  logic [FSh-1:0]    s7_rem_q;
  logic signed [3:0] s7_k_q;
  dbpg_pkg::pix_t    s7_side_q;

  assign e_s = neg_i ? (16'd0 - {1'b0, emag_i}) : {1'b0, emag_i};
  assign i0  = {1'b0, e_s[11:FSh]};
  assign i1  = i0 + 1'b1;
  assign t0  = dbpg_pkg::EXP_TBL[i0];
  assign t1  = dbpg_pkg::EXP_TBL[i1];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s7_t0_q   <= t0;
      s7_diff_q <= t1 - t0;
      s7_rem_q  <= e_s[FSh-1:0];
      s7_k_q    <= $signed(e_s[15:12]);  // floor(e / 4096)
      s7_side_q <= side_i;
    end
  end

  // stage 8: interpolate, Q16
  logic [IpW-1:0]    ip;
  logic [IpW-1:0]    ip_rnd;
  logic [17:0]       s8_v_q;
  logic signed [3:0] s8_k_q;
  dbpg_pkg::pix_t    s8_side_q;

  assign ip     = IpW'(s7_diff_q) * IpW'(s7_rem_q);
  assign ip_rnd = ip + (IpW'(1) << (FSh - 1));

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s8_v_q    <= s7_t0_q + 18'(ip_rnd >> FSh);
      s8_k_q    <= s7_k_q;
      s8_side_q <= s7_side_q;
    end
  end

  // stage 9: gain = round(v * 2^k / 16), saturated
  logic        big;
  logic [3:0]  sh;
  logic [18:0] rnd;
  logic [18:0] gsum;
  logic [18:0] gsh;
  logic [15:0] gain_d;
  logic [15:0]    s9_gain_q;
  dbpg_pkg::pix_t s9_side_q;

  assign big    = !s8_k_q[3] && s8_k_q[2];  // k >= 4: v >= 1.0 already saturates
  assign sh     = 4'd4 - s8_k_q;
  assign rnd    = 19'(1) << (sh - 4'd1);
  assign gsum   = {1'b0, s8_v_q} + rnd;
  assign gsh    = gsum >> sh;
  assign gain_d = (big || (gsh > 19'd65535)) ? 16'hFFFF : gsh[15:0];

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      s9_gain_q <= gain_d;
      s9_side_q <= s8_side_q;
    end
  end

  assign gain_o = s9_gain_q;
  assign side_o = s9_side_q;

endmodule

// File: src/dbpg_scale.sv
// ----------------------------------------------------------------------------
// dbpg_scale: channel scaling, stage 10
// Each channel times the gain, rounded and clipped, or passed through on bypass;
// holds the output register.
module dbpg_scale (
  input  logic           clk_i,
  input  logic           adv_i,
  input  logic [15:0]    gain_i,
  input  dbpg_pkg::pix_t side_i,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o
);

  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [15:0] g,
                                          input logic bypass);
    logic [24:0] acc;
    acc = 25'(24'(c) * 24'(g)) + 25'd2048;
    if (bypass) begin
      return c;
    end else if (|acc[24:20]) begin
      return 8'hFF;
    end else begin
      return acc[19:12];
    end
  endfunction

  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      red_q   <= scale_ch(side_i.red, gain_i, side_i.bypass);
      green_q <= scale_ch(side_i.green, gain_i, side_i.bypass);
      blue_q  <= scale_ch(side_i.blue, gain_i, side_i.bypass);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// File: tb/dodge_burn_pixel_gain_tb.sv
// ----------------------------------------------------------------------------
// dodge_burn_pixel_gain_tb: self-checking bench for the dodge/burn pixel gain
// Drives pixel beats through the block under several exposure and tone
// settings, predicts each adjusted pixel in fixed point and checks the output
// beats in order, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module dodge_burn_pixel_gain_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbpg_pkg::*;

  // tone code with no name in the package; the block treats it as midtones
  localparam logic [1:0] TONE_RESERVED = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] dodge;
    logic [7:0] burn;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_beat_t;

  // --------------------------------------------------------------------------
  // Gain predictor plus in-order result check. Holds its own copy of the two
  // registers and its own exp2 table.
  // --------------------------------------------------------------------------
  class gain_checker;
    int         exposure;
    logic [1:0] tone;
    longint     exp2_q16[TBL_N+1];
    rgb_beat_t  expected_rgb[$];
    int         mismatches;

    function new();
      longint unsigned t, term, acc;
      exposure   = 0;
      tone       = TONE_MID;
      mismatches = 0;
      // 2^(i/N) in Q16: Taylor series of e^x in Q30, x = i*ln2/N
      for (int i = 0; i <= TBL_N; i++) begin
        t    = (longint'(i) * 744261118 + TBL_N / 2) / TBL_N;
        term = longint'(1) << 30;
        acc  = term;
        for (int n = 1; n <= 24 && term != 0; n++) begin
          term = ((term * t) >> 30) / n;
          acc  = acc + term;
        end
        exp2_q16[i] = (acc + (1 << 13)) >> 14;
      end
    endfunction

    function void set_exposure(logic [11:0] raw);
      exposure = int'($signed(raw));
    endfunction

    function void set_tone(logic [1:0] raw);
      tone = raw;
    endfunction

    // Q0.16 tonal weight of a Q0.16 luma
    function longint tone_weight(longint luma);
      longint inv = 65536 - luma;
      case (tone)
        TONE_SHADOW:    return (inv * inv + 32768) >> 16;
        TONE_HIGHLIGHT: return (luma * luma + 32768) >> 16;
        default:        return (4 * luma * inv + 32768) >> 16;
      endcase
    endfunction

    // Q3.12 exponent -> Q4.12 gain via table and linear interpolation
    function longint gain_q12(longint expo);
      longint octave, frac, idx, rem, v, sh, g;
      octave = expo >>> 12;
      frac   = expo - octave * 4096;
      idx    = frac >> FRAC_SH;
      rem    = frac & ((longint'(1) << FRAC_SH) - 1);
      v      = exp2_q16[idx];
      if (FRAC_SH > 0)
        v += ((exp2_q16[idx+1] - exp2_q16[idx]) * rem + (longint'(1) << (FRAC_SH - 1)))
             >> FRAC_SH;
      if (octave >= 4) begin
        sh = octave - 4;
        if (sh > 20) return 65535;
        g = v << sh;
      end else begin
        sh = 4 - octave;
        if (sh > 40) return 0;
        g = (v + (longint'(1) << (sh - 1))) >> sh;
      end
      return (g > 65535) ? 65535 : g;
    endfunction

    function logic [7:0] scale_channel(longint chan, longint gain);
      longint o = (chan * gain + 2048) >> 12;
      return (o > 255) ? 8'd255 : 8'(o);
    endfunction

    function void predict_pixel(pixel_beat_t px);
      longint    r, g, b, net, luma, prod, mag, expo, gain;
      rgb_beat_t res;
      r   = px.red;
      g   = px.green;
      b   = px.blue;
      net = longint'(px.dodge) - longint'(px.burn);
      res = {px.red, px.green, px.blue};
      if (net != 0) begin
        luma = (13933 * r + 46871 * g + 4732 * b + 127) / 255;
        prod = exposure * net * tone_weight(luma);
        mag  = (prod < 0) ? -prod : prod;
        // round half away from zero; 11489280 = 4096 * 255 * 11
        expo = (mag * 5 + 5744640) / 11489280;
        if (prod < 0) expo = -expo;
        gain      = gain_q12(expo);
        res.red   = scale_channel(r, gain);
        res.green = scale_channel(g, gain);
        res.blue  = scale_channel(b, gain);
      end
      expected_rgb.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_rgb(rgb_beat_t got);
      rgb_beat_t want;
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = expected_rgb.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [0:0]            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dbpg_in_if  pix_in ();
  dbpg_out_if pix_out ();

  dodge_burn_pixel_gain i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  gain_checker gain_chk;

  // Per-side upper bound of the random wait drawn before each beat.
  int src_gap_max  = 0;
  int sink_gap_max = 0;
  // One-shot long output stall, picked up by the output side at its next beat.
  int sink_hold    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (~1100 beats).
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Both registers back to back; only called with nothing in flight.
  task automatic apply_setting(logic [11:0] ev, logic [1:0] tone);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_EXPOSURE_EV;
    cfg_wdata <= ev;
    @(posedge clk_i);
    cfg_idx   <= CFG_TONE_RANGE;
    cfg_wdata <= CFG_DATA_W'(tone);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    gain_chk.set_exposure(ev);
    gain_chk.set_tone(tone);
  endtask

  // One input beat. valid is only dropped when a gap is drawn, so back-to-back
  // beats keep it high without a low/high pair in the same step.
  task automatic send_pixel(pixel_beat_t px);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid       <= 1'b1;
    pix_in.red_in      <= px.red;
    pix_in.green_in    <= px.green;
    pix_in.blue_in     <= px.blue;
    pix_in.dodge_level <= px.dodge;
    pix_in.burn_level  <= px.burn;
    do @(posedge clk_i); while (!pix_in.ready);
    gain_chk.predict_pixel(px);
  endtask

  // Mostly uniform pixels, biased toward zero net mask, full-strength masks
  // and black/white channels.
  function automatic pixel_beat_t random_pixel();
    pixel_beat_t px;
    px.red   = 8'($urandom);
    px.green = 8'($urandom);
    px.blue  = 8'($urandom);
    px.dodge = 8'($urandom);
    px.burn  = 8'($urandom);
    case ($urandom_range(0, 9))
      0: px.burn = px.dodge;
      1: begin
        px.dodge = 8'd255;
        px.burn  = 8'd0;
      end
      2: begin
        px.dodge = 8'd0;
        px.burn  = 8'd255;
      end
      3: begin
        px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Drain, reprogram, then stream random beats under the given idling.
  task automatic run_phase(int ev, logic [1:0] tone, int beats, int src_max,
                           int snk_max, int hold);
    pix_in.valid <= 1'b0;
    while (gain_chk.expected_rgb.size() != 0) @(posedge clk_i);
    apply_setting(12'(ev), tone);
    src_gap_max  = src_max;
    sink_gap_max = snk_max;
    sink_hold    = hold;
    repeat (beats) send_pixel(random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall before each beat, check on every accepted beat
  // --------------------------------------------------------------------------
  initial begin
    int        stall;
    rgb_beat_t got;
    pix_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pix_out.ready <= 1'b1;
      do @(posedge clk_i); while (!pix_out.valid);
      got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out};
      gain_chk.check_rgb(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    gain_chk = new();

    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_EXPOSURE_EV;
    cfg_wdata          <= '0;
    pix_in.valid       <= 1'b0;
    pix_in.red_in      <= '0;
    pix_in.green_in    <= '0;
    pix_in.blue_in     <= '0;
    pix_in.dodge_level <= '0;
    pix_in.burn_level  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels at a moderate midtone setting, no idling.
    apply_setting(12'd512, TONE_MID);
    send_pixel({8'd0,   8'd0,   8'd0,   8'd255, 8'd0});    // black, full dodge
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0});    // white, full dodge
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0,   8'd255});  // white, full burn
    send_pixel({8'd0,   8'd0,   8'd0,   8'd0,   8'd255});  // black, full burn
    send_pixel({8'd128, 8'd128, 8'd128, 8'd255, 8'd0});    // mid gray, peak weight
    send_pixel({8'd128, 8'd128, 8'd128, 8'd0,   8'd255});
    send_pixel({8'd255, 8'd0,   8'd0,   8'd255, 8'd0});    // pure primaries
    send_pixel({8'd0,   8'd255, 8'd0,   8'd255, 8'd0});
    send_pixel({8'd0,   8'd0,   8'd255, 8'd0,   8'd255});
    send_pixel({8'd200, 8'd100, 8'd50,  8'd255, 8'd255});  // net zero, both full
    send_pixel({8'd200, 8'd100, 8'd50,  8'd0,   8'd0});    // net zero, both empty
    send_pixel({8'd1,   8'd1,   8'd1,   8'd1,   8'd0});    // smallest dodge
    send_pixel({8'd254, 8'd254, 8'd254, 8'd0,   8'd1});    // smallest burn
    send_pixel({8'd64,  8'd192, 8'd32,  8'd128, 8'd0});
    send_pixel({8'd16,  8'd16,  8'd16,  8'd255, 8'd0});
    send_pixel({8'd240, 8'd240, 8'd240, 8'd0,   8'd255});
    send_pixel({8'd170, 8'd85,  8'd170, 8'd255, 8'd1});
    send_pixel({8'd85,  8'd170, 8'd85,  8'd1,   8'd255});
    src_gap_max  = 4;
    sink_gap_max = 4;
    repeat (100) send_pixel(random_pixel());

    // zero exposure: every pixel must come back unchanged
    run_phase(0, TONE_SHADOW, 60, 0, 0, 0);
    run_phase(1024, TONE_HIGHLIGHT, 130, 4, 0, 0);
    run_phase(-1024, TONE_SHADOW, 130, 0, 4, 0);
    // strongest dodge with a long output stall: pipe fills, input backs up
    run_phase(2047, TONE_MID, 130, 0, 0, 60);
    run_phase(-2048, TONE_HIGHLIGHT, 130, 4, 4, 0);
    // unnamed tone code, falls back to midtones
    run_phase(-300, TONE_RESERVED, 120, 4, 4, 0);
    repeat (3)
      run_phase($urandom_range(0, 4095), 2'($urandom), 100,
                $urandom_range(0, 1) * 4, $urandom_range(0, 1) * 4, 0);

    // Let everything drain, then watch a while longer for stray beats.
    pix_in.valid <= 1'b0;
    while (gain_chk.expected_rgb.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_STAGES) @(posedge clk_i);

    if (gain_chk.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
